// ===== hdl/mkse_pkg.sv =====
package mkse_pkg;

	localparam int unsigned NumRows    = 4;
	localparam int unsigned RowW       = 2;
	localparam int unsigned ColW       = 4;
	localparam int unsigned KeyW       = 4;
	localparam int unsigned ValueW     = 7;
	localparam int unsigned CountW     = 2;
	localparam int unsigned ApbAddrW   = 3;
	localparam int unsigned ApbDataW   = 32;

	// register index, taken from paddr[2]
	localparam logic RegEntryMode = 1'b0;

	localparam logic [KeyW-1:0]   KeyEnter    = 4'd12;
	localparam logic [KeyW-1:0]   KeyClear    = 4'd13;
	localparam logic [KeyW-1:0]   KeyLastDig  = 4'd9;
	localparam logic [CountW-1:0] CountSat    = 2'd3;

	localparam logic ModeSingle = 1'b0;
	localparam logic ModeNumber = 1'b1;

	typedef struct packed {
		logic [RowW-1:0]   scan_row;
		logic [NumRows-1:0] row_pressed;
		logic [CountW-1:0] digit_count;
		logic [KeyW-1:0]   first_digit;
		logic [ValueW-1:0] entered_number;
	} mkse_state_t;

	typedef struct packed {
		logic [NumRows-1:0] row_drive;
		logic               new_press;
		logic [KeyW-1:0]    key_code;
		logic               done_res;
		logic [ValueW-1:0]  result_value;
		logic               display_update;
		logic [ValueW-1:0]  display_value;
	} mkse_result_t;

	// key layout, row by row, column bit 0..3
	function automatic logic [KeyW-1:0] key_lookup(input logic [RowW-1:0] row,
			input logic [1:0] col);
		logic [KeyW-1:0] k;
		unique case ({row, col})
			4'h0: k = 4'd1;
			4'h1: k = 4'd4;
			4'h2: k = 4'd7;
			4'h3: k = 4'd10;
			4'h4: k = 4'd2;
			4'h5: k = 4'd5;
			4'h6: k = 4'd8;
			4'h7: k = 4'd0;
			4'h8: k = 4'd3;
			4'h9: k = 4'd6;
			4'hA: k = 4'd9;
			4'hB: k = 4'd11;
			4'hC: k = 4'd12;
			4'hD: k = 4'd13;
			4'hE: k = 4'd14;
			default: k = 4'd15;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/mkse_step.sv =====
module mkse_step (
	input  logic                                  entry_mode,
	input  logic [mkse_pkg::ColW-1:0]             sample,
	input  mkse_pkg::mkse_state_t                 cur,
	output mkse_pkg::mkse_state_t                 nxt,
	output mkse_pkg::mkse_result_t                res
);

	logic [mkse_pkg::RowW-1:0]    row;
	logic [mkse_pkg::NumRows-1:0] row_bit;
	logic                         one_hot;
	logic [1:0]                   col;
	logic [mkse_pkg::KeyW-1:0]    key;
	logic                         press;
	logic [mkse_pkg::ValueW-1:0]  two_digit;

	assign row     = cur.scan_row;
	assign row_bit = mkse_pkg::NumRows'(1) << row;

	always_comb begin
		one_hot = 1'b1;
		col     = 2'd0;
		unique case (sample)
			4'b0001: col = 2'd0;
			4'b0010: col = 2'd1;
			4'b0100: col = 2'd2;
			4'b1000: col = 2'd3;
			default: one_hot = 1'b0;
		endcase
	end

	assign key = mkse_pkg::key_lookup(row, col);

	// tens digit times ten as two shifts
	assign two_digit = {cur.first_digit, 3'b000} + {2'b00, cur.first_digit, 1'b0}
		+ {3'b000, key};

	always_comb begin
		nxt   = cur;
		res   = '0;
		press = 1'b0;

		if (one_hot) begin
			nxt.row_pressed = cur.row_pressed | row_bit;
			press = (cur.row_pressed & row_bit) == '0;
		end else begin
			nxt.row_pressed = cur.row_pressed & ~row_bit;
		end
		nxt.scan_row = row + mkse_pkg::RowW'(1);

		res.new_press = press;
		if (press) begin
			res.key_code = key;
			priority if (entry_mode == mkse_pkg::ModeSingle) begin
				res.done_res     = 1'b1;
				res.result_value = {3'b000, key};
			end else if (key == mkse_pkg::KeyEnter) begin
				res.done_res     = 1'b1;
				res.result_value = cur.entered_number;
			end else if (key == mkse_pkg::KeyClear) begin
				nxt.digit_count    = '0;
				nxt.first_digit    = '0;
				nxt.entered_number = '0;
				res.display_update = 1'b1;
			end else if (key <= mkse_pkg::KeyLastDig) begin
				if (cur.digit_count == 2'd0) begin
					nxt.first_digit    = key;
					res.display_update = 1'b1;
					res.display_value  = {3'b000, key};
				end else if (cur.digit_count == 2'd1) begin
					nxt.entered_number = two_digit;
					res.display_update = 1'b1;
					res.display_value  = two_digit;
				end
				if (cur.digit_count != mkse_pkg::CountSat) begin
					nxt.digit_count = cur.digit_count + 2'd1;
				end
			end
		end

		// session end wipes flags and entry, scan back to first row
		if (res.done_res) begin
			nxt = '0;
		end
		res.row_drive = mkse_pkg::NumRows'(1) << nxt.scan_row;
	end

endmodule

// ===== hdl/matrix_keypad_scan_entry.sv =====
// Channel   Direction  Handshake                     Payload
// cfg       in/out     APB psel/penable/pwrite       entry_mode at paddr 0
// sample    in         sample_valid/sample_ready     column_sample
// result    out        result_valid/result_ready     row_drive .. display_value
//
// One sample per cycle while sample_ready is high; each word gives its result in the cycle after acceptance.
// The step logic sits between the scan state and a single result register.
// sample_ready is high while the result register is empty or being drained.
// Reset clears the scan state, the mode and result_valid; no clearing pass.
module matrix_keypad_scan_entry (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mkse_pkg::ApbAddrW-1:0]        paddr,
	input  logic [mkse_pkg::ApbDataW-1:0]        pwdata,
	output logic [mkse_pkg::ApbDataW-1:0]        prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [mkse_pkg::ColW-1:0]            column_sample,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [mkse_pkg::NumRows-1:0]         row_drive,
	output logic                                 new_press,
	output logic [mkse_pkg::KeyW-1:0]            key_code,
	output logic                                 done_res,
	output logic [mkse_pkg::ValueW-1:0]          result_value,
	output logic                                 display_update,
	output logic [mkse_pkg::ValueW-1:0]          display_value
);

	logic                   entry_mode_q;
	mkse_pkg::mkse_state_t  state_q;
	mkse_pkg::mkse_state_t  state_nxt;
	mkse_pkg::mkse_result_t step_res;
	mkse_pkg::mkse_result_t res_q;
	logic                   res_valid_q;
	logic                   take;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == mkse_pkg::RegEntryMode)
		? {{(mkse_pkg::ApbDataW-1){1'b0}}, entry_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_mode_q <= mkse_pkg::ModeSingle;
		end else if (psel && penable && pwrite && paddr[2] == mkse_pkg::RegEntryMode) begin
			entry_mode_q <= pwdata[0];
		end
	end

	assign sample_ready = !res_valid_q || result_ready;
	assign take         = sample_valid && sample_ready;

	mkse_step u_step (
		.entry_mode (entry_mode_q),
		.sample     (column_sample),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q <= state_nxt;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= step_res;
		end
	end

	assign result_valid   = res_valid_q;
	assign row_drive      = res_q.row_drive;
	assign new_press      = res_q.new_press;
	assign key_code       = res_q.key_code;
	assign done_res       = res_q.done_res;
	assign result_value   = res_q.result_value;
	assign display_update = res_q.display_update;
	assign display_value  = res_q.display_value;

	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot(row_drive))
		else $error("row_drive not one-hot");

	a_done_no_disp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && done_res |-> !display_update && new_press)
		else $error("session end without press or with display update");

	a_no_press_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !new_press |-> key_code == '0 && !done_res && !display_update)
		else $error("activity without a new press");

	a_session_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && step_res.done_res |=> state_q == '0)
		else $error("scan state not cleared after session end");

endmodule
